/* rtl/led_bps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bps_pkg
// Shared types and constants for the bit-plane LED matrix scanner.
// ----------------------------------------------------------------------------
package led_bps_pkg;

  // Default geometry
  localparam int NUM_SCAN_ROWS_DEF = 7;
  localparam int NUM_PLANES_DEF    = 3;

  // Depth of the row-refresh job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Fixed field widths
  localparam int ROW_W   = 3;
  localparam int PLANE_W = 2;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int BIT_CNT_W = 4;

  // Input item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PLANE0_TICKS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PLANE1_TICKS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PLANE2_TICKS = 2'd2;

  // Reset values
  localparam logic [CFG_W-1:0] PLANE0_TICKS_RST = 8'd2;
  localparam logic [CFG_W-1:0] PLANE1_TICKS_RST = 8'd8;
  localparam logic [CFG_W-1:0] PLANE2_TICKS_RST = 8'd20;
  localparam logic [CFG_W-1:0] FIRST_COUNT      = 8'd21;

  // Row pattern for row zero; later rows shift right
  localparam logic [BYTE_W-1:0] ROW_ONE_HOT = 8'h40;

  // Bit counter value of the row-enable slot
  localparam logic [BIT_CNT_W-1:0] ENABLE_SLOT = 4'd8;

  typedef struct packed {
    logic                mode;
    logic [PLANE_W-1:0]  plane_sel;
    logic [ROW_W-1:0]    row_sel;
    logic [BYTE_W-1:0]   pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] row_drive;
    logic              col_data;
    logic              col_clock;
    logic              last;
  } out_item_t;

  // One row refresh: byte to shift, row pattern, end-of-refresh flag
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] row_drive;
    logic              last;
  } job_t;

endpackage

/* rtl/led_bps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bps_front
// Accepts input items: stores frame bytes, counts timer ticks, and on expiry
// queues one row refresh job and advances the scan position.
// ----------------------------------------------------------------------------
module led_bps_front #(
  parameter int NUM_SCAN_ROWS = led_bps_pkg::NUM_SCAN_ROWS_DEF,
  parameter int NUM_PLANES    = led_bps_pkg::NUM_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  led_bps_pkg::in_item_t               in_item,
  input  logic                                q_full,
  output logic                                in_stall,
  input  logic                                cfg_we,
  input  logic [led_bps_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [led_bps_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                                push,
  output led_bps_pkg::job_t                   push_job
);

  localparam int FS_DEPTH = NUM_PLANES * NUM_SCAN_ROWS;
  localparam int IDX_W    = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;
  localparam logic [led_bps_pkg::ROW_W-1:0]   LAST_ROW   =
    led_bps_pkg::ROW_W'(NUM_SCAN_ROWS - 1);
  localparam logic [led_bps_pkg::PLANE_W-1:0] LAST_PLANE =
    led_bps_pkg::PLANE_W'(NUM_PLANES - 1);

  logic [led_bps_pkg::BYTE_W-1:0]  fs_r [FS_DEPTH];
  logic [led_bps_pkg::CFG_W-1:0]   plane0_ticks_r, plane1_ticks_r, plane2_ticks_r;
  logic [led_bps_pkg::CFG_W-1:0]   ticks_left_r, ticks_left_nxt;
  logic [led_bps_pkg::ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [led_bps_pkg::PLANE_W-1:0] scan_plane_r, scan_plane_nxt;

  logic                            in_acc;
  logic                            tick;
  logic                            wr_en;
  logic                            expire;
  logic [led_bps_pkg::CFG_W-1:0]   ticks_dec;
  logic [led_bps_pkg::CFG_W-1:0]   reload;
  logic [IDX_W-1:0]                wr_idx;
  logic [IDX_W-1:0]                rd_idx;

  // Handshake and item decode
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;
  assign tick     = in_acc && (in_item.mode == led_bps_pkg::MODE_TICK);
  assign wr_en    = in_acc && (in_item.mode == led_bps_pkg::MODE_WRITE) &&
                    ({1'b0, in_item.plane_sel} < 3'(NUM_PLANES)) &&
                    ({1'b0, in_item.row_sel} < 4'(NUM_SCAN_ROWS));

  assign ticks_dec = ticks_left_r - 8'd1;
  assign expire    = tick && (ticks_dec == '0);
  assign push      = expire;

  assign wr_idx = IDX_W'(in_item.plane_sel * NUM_SCAN_ROWS + in_item.row_sel);
  assign rd_idx = IDX_W'(scan_plane_r * NUM_SCAN_ROWS + scan_row_r);

  // Lit time of the plane being refreshed
  always_comb begin
    case (scan_plane_r)
      2'd0:    reload = plane0_ticks_r;
      2'd1:    reload = plane1_ticks_r;
      default: reload = plane2_ticks_r;
    endcase
  end

  // Refresh job for the current row
  always_comb begin
    push_job.data      = fs_r[rd_idx];
    push_job.row_drive = led_bps_pkg::ROW_ONE_HOT >> scan_row_r;
    push_job.last      = (scan_row_r == LAST_ROW) && (scan_plane_r == LAST_PLANE);
  end

  // Countdown and scan position
  always_comb begin
    ticks_left_nxt = ticks_left_r;
    scan_row_nxt   = scan_row_r;
    scan_plane_nxt = scan_plane_r;
    if (expire) begin
      ticks_left_nxt = reload;
      if (scan_row_r == LAST_ROW) begin
        scan_row_nxt   = '0;
        scan_plane_nxt = (scan_plane_r == LAST_PLANE) ? '0 : scan_plane_r + 2'd1;
      end else begin
        scan_row_nxt = scan_row_r + 3'd1;
      end
    end else if (tick) begin
      ticks_left_nxt = ticks_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_left_r <= led_bps_pkg::FIRST_COUNT;
      scan_row_r   <= '0;
      scan_plane_r <= '0;
    end else begin
      ticks_left_r <= ticks_left_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_plane_r <= scan_plane_nxt;
    end
  end

  // Plane lit-time registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane0_ticks_r <= led_bps_pkg::PLANE0_TICKS_RST;
      plane1_ticks_r <= led_bps_pkg::PLANE1_TICKS_RST;
      plane2_ticks_r <= led_bps_pkg::PLANE2_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == led_bps_pkg::CFG_PLANE0_TICKS) plane0_ticks_r <= cfg_wdata;
      if (cfg_index == led_bps_pkg::CFG_PLANE1_TICKS) plane1_ticks_r <= cfg_wdata;
      if (cfg_index == led_bps_pkg::CFG_PLANE2_TICKS) plane2_ticks_r <= cfg_wdata;
    end
  end

  // Frame store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FS_DEPTH; i++) begin
        fs_r[i] <= '0;
      end
    end else if (wr_en) begin
      fs_r[wr_idx] <= in_item.pixel_byte;
    end
  end

  // A job is queued only by an accepted tick
  a_push_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_valid && !in_stall && in_item.mode == led_bps_pkg::MODE_TICK))
    else $error("job queued without an accepted tick");

  // Scan position stays inside the frame
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, scan_plane_r} < 3'(NUM_PLANES)) && ({1'b0, scan_row_r} < 4'(NUM_SCAN_ROWS)))
    else $error("scan position outside frame");

  // Input held off whenever the job queue is full
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall)
    else $error("input taken while job queue full");

endmodule

/* rtl/led_bps_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bps_fifo
// Short queue of row refresh jobs between the front and the back.
// ----------------------------------------------------------------------------
module led_bps_fifo #(
  parameter int DEPTH = led_bps_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  led_bps_pkg::job_t push_job,
  input  logic              pop,
  output led_bps_pkg::job_t pop_job,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  led_bps_pkg::job_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign pop_job = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Job slots
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count out of range");

endmodule

/* rtl/led_bps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_bps_back
// Plays out one refresh job as eight shift items and one row-enable item,
// through a registered output stage.
// ----------------------------------------------------------------------------
module led_bps_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  led_bps_pkg::job_t      q_job,
  output logic                   pop,
  output logic                   out_valid,
  output led_bps_pkg::out_item_t out_item,
  input  logic                   out_stall
);

  logic                                 cur_valid_r;
  led_bps_pkg::job_t                    cur_job_r;
  logic [led_bps_pkg::BIT_CNT_W-1:0]    cnt_r;
  logic                                 out_valid_r;
  led_bps_pkg::out_item_t               out_item_r;
  led_bps_pkg::out_item_t               item_nxt;
  logic                                 advance;
  logic                                 job_done;

  // Next item of the current job
  always_comb begin
    if (cnt_r == led_bps_pkg::ENABLE_SLOT) begin
      item_nxt.row_drive = cur_job_r.row_drive;
      item_nxt.col_data  = 1'b0;
      item_nxt.col_clock = 1'b0;
      item_nxt.last      = cur_job_r.last;
    end else begin
      item_nxt.row_drive = '0;
      item_nxt.col_data  = cur_job_r.data[cnt_r[2:0]];
      item_nxt.col_clock = 1'b1;
      item_nxt.last      = 1'b0;
    end
  end

  assign advance  = cur_valid_r && (!out_valid_r || !out_stall);
  assign job_done = advance && (cnt_r == led_bps_pkg::ENABLE_SLOT);
  assign pop      = !q_empty && (!cur_valid_r || job_done);

  // Current job and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      cnt_r       <= '0;
    end else if (job_done) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (advance) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_job_r <= q_job;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item_r <= item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= led_bps_pkg::ENABLE_SLOT)
    else $error("bit counter past enable slot");

  a_last_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |-> (out_item_r.row_drive != '0 &&
                                          !out_item_r.col_clock))
    else $error("refresh end without a lit row");

  // A stalled output item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("stalled output item changed");

endmodule

/* rtl/led_matrix_bitplane_scanner_top.sv */
`timescale 1ns / 1ps
// An expiring tick item queues a refresh job, which the back end pops and plays out on out_valid.
// Each expiry gives 9 result items, one per cycle while not stalled, set by the back-end bit counter.
// Input items are taken one per cycle while the 2-deep job queue has room.
// Sustained rate is bounded by the back end, which plays out one row refresh job at a time.
// Reset (synchronous, rst_n low) clears the frame store, scan position and queue,
// loads the countdown with 21 and the plane lit times with 2, 8 and 20.
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner_top
// Multiplexed LED matrix scanner with bit-plane intensity control.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_scanner_top #(
  parameter int NUM_SCAN_ROWS = led_bps_pkg::NUM_SCAN_ROWS_DEF,
  parameter int NUM_PLANES    = led_bps_pkg::NUM_PLANES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  led_bps_pkg::in_item_t          in_item,
  output logic                           in_stall,
  output logic                           out_valid,
  output led_bps_pkg::out_item_t         out_item,
  input  logic                           out_stall,
  input  logic                           cfg_we,
  input  logic [led_bps_pkg::CIDX_W-1:0] cfg_index,
  input  logic [led_bps_pkg::CFG_W-1:0]  cfg_wdata
);

  logic              push, pop, q_empty, q_full;
  led_bps_pkg::job_t push_job, pop_job;

  // Front: item decode, frame store, countdown
  led_bps_front #(
    .NUM_SCAN_ROWS (NUM_SCAN_ROWS),
    .NUM_PLANES    (NUM_PLANES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue
  led_bps_fifo #(
    .DEPTH (led_bps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: serial shift-out and row enable
  led_bps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

/* tb/tb_led_matrix_bitplane_scanner_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_bitplane_scanner_top
// Self-checking bench for the bit-plane LED matrix scanner. Frame writes and
// timer ticks go in through the valid/stall input channel. A scan model kept in
// the bench predicts each row refresh: eight shift beats and then the row
// enable. Every beat taken at the output is compared with the oldest predicted
// one. Lit times are rewritten between phases, and both the sender and the
// receiver idle at random.
// ----------------------------------------------------------------------------
module tb_led_matrix_bitplane_scanner_top;

  localparam int NUM_SCAN_ROWS  = led_bps_pkg::NUM_SCAN_ROWS_DEF;
  localparam int NUM_PLANES     = led_bps_pkg::NUM_PLANES_DEF;
  localparam int RESET_CYCLES   = 6;
  localparam int DRAIN_PAUSE    = 12;     // idle pause after the last predicted beat has come out
  localparam int LONG_HOLD      = 150;    // receiver hold-off when filling the block
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int MIX_ITEMS      = 23;     // items per random phase
  localparam int ZERO_LIT_TICKS = 24;     // ticks sent after a zero lit time reload
  localparam logic [led_bps_pkg::CIDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  led_bps_pkg::in_item_t             in_item   = '0;
  logic                              in_stall;
  logic                              out_valid;
  led_bps_pkg::out_item_t            out_item;
  logic                              out_stall = 1'b0;
  logic                              cfg_we    = 1'b0;
  logic [led_bps_pkg::CIDX_W-1:0]    cfg_index = '0;
  logic [led_bps_pkg::CFG_W-1:0]     cfg_wdata = '0;

  led_matrix_bitplane_scanner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Scan model state
  logic [led_bps_pkg::BYTE_W-1:0]  frame_bytes [NUM_PLANES][NUM_SCAN_ROWS];
  logic [led_bps_pkg::CFG_W-1:0]   lit_ticks [NUM_PLANES];
  logic [led_bps_pkg::ROW_W-1:0]   scan_row;
  logic [led_bps_pkg::PLANE_W-1:0] scan_plane;
  logic [led_bps_pkg::CFG_W-1:0]   countdown;
  led_bps_pkg::out_item_t          pending_drive [$];

  // Run statistics
  int write_count;
  int tick_count;
  int refresh_count;
  int frame_count;
  int cfg_count;
  int beats_checked;
  int mismatch_count;

  // Sender burst shaping, receiver hold request
  int burst_left;
  bit gaps_on;
  int hold_req;
  int hold_seen;
  int hold_left;
  int stall_pct;
  int pattern_cnt;
  int idle_cycles;

  led_bps_pkg::out_item_t head_beat;

  // Apply one accepted item to the scan model, queue the drive beats it causes
  task automatic advance_scanner(input led_bps_pkg::in_item_t it);
    led_bps_pkg::out_item_t beat;
    logic [led_bps_pkg::BYTE_W-1:0] pix;
    if (it.mode == led_bps_pkg::MODE_WRITE) begin
      write_count++;
      if (it.plane_sel < NUM_PLANES && it.row_sel < NUM_SCAN_ROWS)
        frame_bytes[it.plane_sel][it.row_sel] = it.pixel_byte;
    end else begin
      tick_count++;
      countdown = countdown - 8'd1;
      if (countdown == '0) begin
        pix = frame_bytes[scan_plane][scan_row];
        // rows blanked while the byte goes out LSB first
        for (int k = 0; k < 8; k++) begin
          beat.row_drive = '0;
          beat.col_data  = pix[k];
          beat.col_clock = 1'b1;
          beat.last      = 1'b0;
          pending_drive.push_back(beat);
        end
        beat.row_drive = led_bps_pkg::ROW_ONE_HOT >> scan_row;
        beat.col_data  = 1'b0;
        beat.col_clock = 1'b0;
        beat.last      = (scan_row == NUM_SCAN_ROWS - 1) && (scan_plane == NUM_PLANES - 1);
        pending_drive.push_back(beat);
        if (beat.last) frame_count++;
        refresh_count++;
        countdown = lit_ticks[scan_plane];
        if (scan_row == NUM_SCAN_ROWS - 1) begin
          scan_row   = '0;
          scan_plane = (scan_plane == NUM_PLANES - 1) ? '0 : scan_plane + 1'b1;
        end else begin
          scan_row = scan_row + 1'b1;
        end
      end
    end
  endtask

  // Offer one item, honoring the burst/gap pattern; returns once accepted
  task automatic send_item(input led_bps_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_scanner(it);
  endtask

  function automatic led_bps_pkg::in_item_t tick_item();
    led_bps_pkg::in_item_t it;
    it.mode       = led_bps_pkg::MODE_TICK;
    it.plane_sel  = led_bps_pkg::PLANE_W'($urandom_range(0, 3));
    it.row_sel    = led_bps_pkg::ROW_W'($urandom_range(0, 7));
    it.pixel_byte = led_bps_pkg::BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic led_bps_pkg::in_item_t write_item(
    input int plane, input int row, input logic [led_bps_pkg::BYTE_W-1:0] pix);
    led_bps_pkg::in_item_t it;
    it.mode       = led_bps_pkg::MODE_WRITE;
    it.plane_sel  = led_bps_pkg::PLANE_W'(plane);
    it.row_sel    = led_bps_pkg::ROW_W'(row);
    it.pixel_byte = pix;
    return it;
  endfunction

  // Full field range: planes 3 and rows 7 fall outside the store
  function automatic led_bps_pkg::in_item_t rand_write();
    return write_item($urandom_range(0, 3), $urandom_range(0, 7),
                      led_bps_pkg::BYTE_W'($urandom_range(0, 255)));
  endfunction

  // Send ticks (and some writes) until n more row refreshes are predicted
  task automatic run_refreshes(input int n, input int write_pct);
    int target;
    target = refresh_count + n;
    while (refresh_count < target) begin
      if ($urandom_range(0, 99) < write_pct) send_item(rand_write());
      else send_item(tick_item());
    end
  endtask

  // Stop offering and wait until every predicted beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [led_bps_pkg::CIDX_W-1:0] idx,
                           input logic [led_bps_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx <= led_bps_pkg::CFG_PLANE2_TICKS) lit_ticks[idx] = val;
    cfg_count++;
  endtask

  // Only call while drained; the unused index must leave the lit times alone
  task automatic set_lit_times(input logic [led_bps_pkg::CFG_W-1:0] t0,
                               input logic [led_bps_pkg::CFG_W-1:0] t1,
                               input logic [led_bps_pkg::CFG_W-1:0] t2);
    cfg_write(led_bps_pkg::CFG_PLANE0_TICKS, t0);
    cfg_write(CFG_UNUSED_IDX, led_bps_pkg::CFG_W'($urandom_range(0, 255)));
    cfg_write(led_bps_pkg::CFG_PLANE1_TICKS, t1);
    cfg_write(led_bps_pkg::CFG_PLANE2_TICKS, t2);
  endtask

  // Reset lit times, corner bytes, writes outside the store, first expiry at 21
  task automatic test_directed();
    gaps_on = 1'b1;
    send_item(write_item(0, 0, 8'hFF));
    send_item(write_item(2, 6, 8'hA5));
    send_item(write_item(1, 0, 8'h01));
    send_item(write_item(3, 0, 8'h55));
    send_item(write_item(0, 7, 8'h55));
    send_item(write_item(3, 7, 8'hFF));
    send_item(write_item(0, 1, 8'h80));
    run_refreshes(3, 0);
  endtask

  // Fastest lit time on every plane, whole frame incl. the end-of-refresh flag
  task automatic test_full_refresh();
    wait_drained();
    set_lit_times(8'd1, 8'd1, 8'd1);
    for (int p = 0; p < NUM_PLANES; p++)
      for (int r = 0; r < NUM_SCAN_ROWS; r++)
        send_item(write_item(p, r, led_bps_pkg::BYTE_W'($urandom_range(0, 255))));
    run_refreshes(NUM_PLANES * NUM_SCAN_ROWS + 1, 0);
  endtask

  // Maximum lit time everywhere, then zero on the plane in scan: the countdown
  // wraps to 256 counts, so no refresh may follow within the next ticks
  task automatic test_lit_extremes();
    wait_drained();
    set_lit_times(8'd255, 8'd255, 8'd255);
    cfg_write(scan_plane, 8'd0);
    run_refreshes(1, 0);
    repeat (ZERO_LIT_TICKS) send_item(tick_item());
  endtask

  // Receiver holds off while ticks keep expiring, so the job queue backs up
  task automatic test_stall_fill();
    wait_drained();
    set_lit_times(8'd1, 8'd1, 8'd1);
    gaps_on = 1'b0;
    hold_req <= hold_req + 1;
    repeat (16) send_item(tick_item());
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Mixed writes and ticks under several short lit-time settings
  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      set_lit_times(led_bps_pkg::CFG_W'($urandom_range(1, 5)),
                    led_bps_pkg::CFG_W'($urandom_range(1, 5)),
                    led_bps_pkg::CFG_W'($urandom_range(1, 5)));
      gaps_on = (phase != 1);
      repeat (MIX_ITEMS) begin
        if ($urandom_range(0, 99) < 55) send_item(tick_item());
        else send_item(rand_write());
      end
    end
  endtask

  // Receiver: long hold on request, otherwise stall odds that change over time
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      pattern_cnt <= 0;
      stall_pct   <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      pattern_cnt <= (pattern_cnt == 47) ? 0 : pattern_cnt + 1;
      if (pattern_cnt == 47) begin
        case ($urandom_range(0, 3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 25;
          default: stall_pct <= 50;
        endcase
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted beat with the oldest predicted one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected beat: row %02h data %0b clk %0b last %0b",
                   out_item.row_drive, out_item.col_data, out_item.col_clock,
                   out_item.last);
      end else begin
        head_beat = pending_drive.pop_front();
        if (out_item.row_drive !== head_beat.row_drive ||
            out_item.col_data  !== head_beat.col_data  ||
            out_item.col_clock !== head_beat.col_clock ||
            out_item.last      !== head_beat.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("beat %0d: expected row %02h data %0b clk %0b last %0b",
                     beats_checked, head_beat.row_drive, head_beat.col_data,
                     head_beat.col_clock, head_beat.last);
            $display("  got row %02h data %0b clk %0b last %0b",
                     out_item.row_drive, out_item.col_data, out_item.col_clock,
                     out_item.last);
          end
        end
      end
      beats_checked++;
    end
  end

  // Watchdog: ends a run in which nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("led_matrix_bitplane_scanner_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (frame_bytes[p, r]) frame_bytes[p][r] = '0;
    lit_ticks[0] = led_bps_pkg::PLANE0_TICKS_RST;
    lit_ticks[1] = led_bps_pkg::PLANE1_TICKS_RST;
    lit_ticks[2] = led_bps_pkg::PLANE2_TICKS_RST;
    scan_row   = '0;
    scan_plane = '0;
    countdown  = led_bps_pkg::FIRST_COUNT;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_req   = 0;
    hold_seen  = 0;
    idle_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_refresh();
    test_stall_fill();
    test_random_mix();
    test_lit_extremes();
    wait_drained();

    $display("covered %0d frame writes, %0d ticks, %0d row refreshes, %0d full frames",
             write_count, tick_count, refresh_count, frame_count);
    $display("%0d register writes, %0d drive beats compared", cfg_count, beats_checked);
    if (mismatch_count == 0 && pending_drive.size() == 0) begin
      $display("led_matrix_bitplane_scanner_top: match");
    end else begin
      $display("led_matrix_bitplane_scanner_top: mismatch");
    end
    $finish;
  end

endmodule

/* led_matrix_bitplane_scanner_top.f */
rtl/led_bps_pkg.sv
rtl/led_bps_front.sv
rtl/led_bps_fifo.sv
rtl/led_bps_back.sv
rtl/led_matrix_bitplane_scanner_top.sv
tb/tb_led_matrix_bitplane_scanner_top.sv
